// ===== hdl/qrht_pkg.sv =====
`timescale 1ns / 1ps
package qrht_pkg;

	localparam logic [1:0] MODE_STORE  = 2'd0;
	localparam logic [1:0] MODE_ENABLE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	localparam logic [1:0] CFG_VIEW_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_VIEW_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_AXIS_TOL    = 2'd2;
	localparam logic [1:0] CFG_CROSS_TOL   = 2'd3;

	localparam logic [12:0] VIEW_RESET      = 13'd512;
	localparam logic [15:0] AXIS_TOL_RESET  = 16'd7;
	localparam logic [39:0] CROSS_TOL_RESET = 40'd28147497671;

	localparam int DIV_W = 32;
	localparam int MUL_W = 27;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W = 77;

	typedef logic signed [23:0] img_t;
	typedef logic signed [24:0] rel_t;

	typedef struct packed {
		rel_t x;
		rel_t y;
	} corner_rel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CX_MUL,
		ST_CX_DST,
		ST_CX_DIV,
		ST_CY_MUL,
		ST_CY_DST,
		ST_CY_DIV,
		ST_DISPATCH,
		ST_REG_CHECK,
		ST_LOAD,
		ST_EDGE,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_SCAN,
		ST_REG_END,
		ST_DONE
	} state_t;

	function automatic logic [24:0] mag25(input rel_t v);
		logic [24:0] m;
		m = v[24] ? 25'(-v) : 25'(v);
		return m;
	endfunction

	function automatic logic opposite(input rel_t a, input rel_t b);
		logic ap, an, bp, bn;
		ap = !a[24] && (a != '0);
		an = a[24];
		bp = !b[24] && (b != '0);
		bn = b[24];
		return (ap && bn) || (an && bp);
	endfunction

	function automatic img_t sat_img(input logic neg, input logic [DIV_W-1:0] m);
		img_t r;
		if (neg) begin
			if (m > DIV_W'(32'd8388608))
				r = 24'sh800000;
			else
				r = img_t'(-m[23:0]);
		end else begin
			if (m > DIV_W'(32'd8388607))
				r = 24'sh7FFFFF;
			else
				r = img_t'(m[23:0]);
		end
		return r;
	endfunction

endpackage

// ===== hdl/qrht_ifs.sv =====
`timescale 1ns / 1ps
interface qrht_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [3:0]         region_index;
	logic [1:0]         corner_index;
	logic signed [17:0] coord_x;
	logic signed [17:0] coord_y;
	logic               enable_flag;

	modport source (output valid, mode, region_index, corner_index, coord_x, coord_y,
		enable_flag, input ready);
	modport sink (input valid, mode, region_index, corner_index, coord_x, coord_y,
		enable_flag, output ready);
endinterface

interface qrht_result_if;
	logic       valid;
	logic       ready;
	logic       hit_found;
	logic [3:0] hit_index;

	modport source (output valid, hit_found, hit_index, input ready);
	modport sink (input valid, hit_found, hit_index, output ready);
endinterface

// ===== hdl/qrht_mul.sv =====
`timescale 1ns / 1ps
module qrht_mul import qrht_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ===== hdl/qrht_div.sv =====
`timescale 1ns / 1ps
module qrht_div import qrht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [12:0]      den,
	output logic             busy,
	output logic [DIV_W-1:0] quo
);

	logic             busy_q;
	logic [4:0]       cnt_q;
	logic [12:0]      rem_q;
	logic [12:0]      den_q;
	logic [DIV_W-1:0] quo_q;
	logic [14:0]      diff;

	assign diff = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(DIV_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			if (!diff[14]) begin
				rem_q <= diff[12:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[11:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== hdl/quad_region_hit_test_top.sv =====
`timescale 1ns / 1ps
// channel     | dir | transfer when          | payload
// item_in     | in  | valid && ready         | mode, region_index, corner_index, coord_x/y,
//             |     |                        | enable_flag
// result_out  | out | valid && ready         | hit_found, hit_index
// cfg         | in  | cfg_wr_en at clk edge  | cfg_index, cfg_data
//
// Each item: one multiply and a 32-step serial divide per coordinate, then the dispatch,
// done and idle states before the next transfer. A query passes the check state for each
// disabled region; an enabled region adds the check and load states, the edge state and
// multiply or scan states per edge on the shared multiplier, and the end state. item_in is
// ready only when idle; the result register frees the core while a result waits, and a
// second result holds it in the done state. arst_n resets control, enable bits and config.
module quad_region_hit_test_top import qrht_pkg::*; #(
	parameter int REGIONS = 16,
	parameter int CORNERS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	qrht_item_if.sink           item_in,
	qrht_result_if.source       result_out,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [39:0]         cfg_data
);

	localparam int RW  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int CW  = $clog2(CORNERS);
	localparam int CW1 = $clog2(CORNERS + 1);
	localparam int DEPTH = REGIONS * CORNERS;
	localparam int AW  = $clog2(DEPTH);

	state_t state_q, state_d;

	logic [12:0] view_w_q, view_h_q;
	logic [15:0] atol_q;
	logic [39:0] ctol_q;
	logic [REGIONS-1:0] en_q;

	logic [1:0]         mode_q;
	logic [3:0]         region_q;
	logic [1:0]         corner_q;
	logic signed [17:0] sx_q, sy_q;
	logic               flag_q;

	img_t px_q, py_q;
	logic neg_q;

	logic [RW-1:0]  r_q;
	logic [CW1-1:0] k_q;
	logic [CW-1:0]  i_q;
	logic [CW1-1:0] j_q;
	corner_rel_t    rot_q [CORNERS];
	rel_t           fx_q;
	logic signed [50:0]      c_q;
	logic signed [25:0]      e_q;
	logic [ACC_W-1:0]        acc_q;
	logic par_q, hit_q;
	logic found_q;
	logic [3:0] idx_q;

	logic       out_valid_q;
	logic       out_found_q;
	logic [3:0] out_index_q;

	logic [47:0]   mem [DEPTH];
	logic [47:0]   rd_q;
	logic          mem_we;
	logic [AW-1:0] waddr, raddr;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        prod_mag;
	logic                     div_start, div_busy;
	logic [DIV_W-1:0]         div_num, div_quo;

	logic [12:0] w_eff, h_eff, minl;
	logic signed [18:0] sx_c, sy_c;

	rel_t f_x, f_y, e_x, e_y;
	logic opp_fe, near_ex, near_ey, ey_pos, i_last, r_last, out_free;
	logic scan_stop, scan_opp, tail_opp, cross_hit, cnt_cond, hit_now, in_range;
	logic [49:0] cmag;
	logic [25:0] emag;
	logic [ACC_W-1:0] cross_sum;
	logic accept;

	assign w_eff = (view_w_q == '0) ? 13'd1 : view_w_q;
	assign h_eff = (view_h_q == '0) ? 13'd1 : view_h_q;
	assign minl  = (w_eff < h_eff) ? w_eff : h_eff;
	assign sx_c  = 19'(sx_q) - 19'sd32768;
	assign sy_c  = 19'(sy_q) - 19'sd32768;

	assign f_x = rot_q[0].x;
	assign f_y = rot_q[0].y;
	assign e_x = rot_q[1].x;
	assign e_y = rot_q[1].y;
	assign opp_fe  = opposite(f_x, e_x);
	assign near_ex = mag25(e_x) < {9'd0, atol_q};
	assign near_ey = mag25(e_y) < {9'd0, atol_q};
	assign ey_pos  = !e_y[24] && (e_y != '0);
	assign i_last  = (i_q == CW'(CORNERS - 1));
	assign r_last  = (r_q == RW'(REGIONS - 1));
	assign scan_stop = (mag25(rot_q[0].x) > {9'd0, atol_q}) || (j_q == CW1'(CORNERS));
	assign scan_opp  = opposite(fx_q, rot_q[0].x);
	assign tail_opp  = opposite(f_x, rot_q[2].x);

	assign cmag = c_q[50] ? 50'(-c_q) : 50'(c_q);
	assign emag = e_q[25] ? 26'(-e_q) : 26'(e_q);
	assign cross_sum = acc_q + ACC_W'(prod);
	assign cross_hit = cross_sum < {37'd0, ctol_q};
	assign cnt_cond  = (c_q != '0) && ((!c_q[50]) == (!e_q[25] && (e_q != '0)));
	assign hit_now   = hit_q || par_q;

	assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
	assign div_num  = {prod_mag[DIV_W-2:0], 1'b0};

	assign in_range = ({5'd0, region_q} < 9'(REGIONS)) && ({2'd0, corner_q} < 4'(CORNERS));
	assign waddr = AW'(32'(region_q) * 32'(CORNERS) + 32'(corner_q));
	assign raddr = AW'(32'(r_q) * 32'(CORNERS) + 32'(k_q));

	assign accept   = item_in.valid && item_in.ready;
	assign out_free = !out_valid_q || result_out.ready;

	qrht_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	qrht_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (minl),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (accept) state_d = ST_CX_MUL;
			ST_CX_MUL:    state_d = ST_CX_DST;
			ST_CX_DST:    state_d = ST_CX_DIV;
			ST_CX_DIV:    if (!div_busy) state_d = ST_CY_MUL;
			ST_CY_MUL:    state_d = ST_CY_DST;
			ST_CY_DST:    state_d = ST_CY_DIV;
			ST_CY_DIV:    if (!div_busy) state_d = ST_DISPATCH;
			ST_DISPATCH:  state_d = (mode_q == MODE_QUERY) ? ST_REG_CHECK : ST_DONE;
			ST_REG_CHECK: begin
				if (en_q[r_q])
					state_d = ST_LOAD;
				else if (r_last)
					state_d = ST_DONE;
			end
			ST_LOAD:      if (k_q == CW1'(CORNERS)) state_d = ST_EDGE;
			ST_EDGE: begin
				priority if (opp_fe)
					state_d = ST_M1;
				else if (near_ex && ey_pos)
					state_d = i_last ? ST_REG_END : ST_SCAN;
				else if (near_ex && near_ey)
					state_d = ST_REG_END;
				else
					state_d = i_last ? ST_REG_END : ST_EDGE;
			end
			ST_M1:        state_d = ST_M2;
			ST_M2:        state_d = ST_M3;
			ST_M3:        state_d = ST_M4;
			ST_M4:        state_d = ST_M5;
			ST_M5:        state_d = ST_M6;
			ST_M6:        state_d = (cross_hit || i_last) ? ST_REG_END : ST_EDGE;
			ST_SCAN: begin
				if (scan_stop)
					state_d = (j_q == CW1'(CORNERS)) ? ST_REG_END : ST_EDGE;
			end
			ST_REG_END:   state_d = (hit_now || r_last) ? ST_DONE : ST_REG_CHECK;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_in.ready = (state_q == ST_IDLE);
		div_start = (state_q == ST_CX_DST) || (state_q == ST_CY_DST);
		mem_we = (state_q == ST_DISPATCH) && (mode_q == MODE_STORE) && in_range;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_CX_MUL: begin
				mul_a = MUL_W'(sx_c);
				mul_b = MUL_W'({1'b0, w_eff});
			end
			ST_CY_MUL: begin
				mul_a = MUL_W'(sy_c);
				mul_b = MUL_W'({1'b0, h_eff});
			end
			ST_M1: begin
				mul_a = MUL_W'(f_x);
				mul_b = MUL_W'(e_y);
			end
			ST_M2: begin
				mul_a = MUL_W'(f_y);
				mul_b = MUL_W'(e_x);
			end
			ST_M4: begin
				mul_a = MUL_W'({3'd0, cmag[49:26]});
				mul_b = MUL_W'({1'b0, emag});
			end
			ST_M5: begin
				mul_a = MUL_W'({1'b0, cmag[25:0]});
				mul_b = MUL_W'({1'b0, emag});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign result_out.valid     = out_valid_q;
	assign result_out.hit_found = out_found_q;
	assign result_out.hit_index = out_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			en_q        <= '0;
			view_w_q    <= VIEW_RESET;
			view_h_q    <= VIEW_RESET;
			atol_q      <= AXIS_TOL_RESET;
			ctol_q      <= CROSS_TOL_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (result_out.ready)
				out_valid_q <= 1'b0;
			if (state_q == ST_DISPATCH && mode_q == MODE_ENABLE
					&& {5'd0, region_q} < 9'(REGIONS))
				en_q[RW'(region_q)] <= flag_q;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_VIEW_WIDTH:  view_w_q <= cfg_data[12:0];
					CFG_VIEW_HEIGHT: view_h_q <= cfg_data[12:0];
					CFG_AXIS_TOL:    atol_q   <= cfg_data[15:0];
					CFG_CROSS_TOL:   ctol_q   <= cfg_data;
					default:         ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= {px_q, py_q};
		if (k_q < CW1'(CORNERS))
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_found_q <= found_q;
			out_index_q <= idx_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q   <= item_in.mode;
					region_q <= item_in.region_index;
					corner_q <= item_in.corner_index;
					sx_q     <= item_in.coord_x;
					sy_q     <= item_in.coord_y;
					flag_q   <= item_in.enable_flag;
				end
				k_q <= CW1'(CORNERS);
			end
			ST_CX_DST, ST_CY_DST: neg_q <= prod[PROD_W-1];
			ST_CX_DIV: if (!div_busy) px_q <= sat_img(neg_q, div_quo);
			ST_CY_DIV: if (!div_busy) py_q <= sat_img(neg_q, div_quo);
			ST_DISPATCH: begin
				found_q <= 1'b0;
				idx_q   <= '0;
				r_q     <= '0;
			end
			ST_REG_CHECK: begin
				k_q   <= '0;
				par_q <= 1'b0;
				hit_q <= 1'b0;
				if (!en_q[r_q])
					r_q <= r_q + RW'(1);
			end
			ST_LOAD: begin
				if (k_q != '0) begin
					for (int m = 0; m < CORNERS; m++) begin
						if (m == CORNERS - 1) begin
							rot_q[m].x <= rel_t'($signed(rd_q[47:24])) - rel_t'(px_q);
							rot_q[m].y <= rel_t'($signed(rd_q[23:0])) - rel_t'(py_q);
						end else begin
							rot_q[m] <= rot_q[(m + 1) % CORNERS];
						end
					end
				end
				if (k_q != CW1'(CORNERS))
					k_q <= k_q + CW1'(1);
				i_q <= '0;
			end
			ST_EDGE: begin
				priority if (opp_fe) begin
					e_q <= 26'(f_x) - 26'(e_x);
				end else if (near_ex && ey_pos) begin
					fx_q <= f_x;
					if (i_last) begin
						if (tail_opp)
							par_q <= !par_q;
					end else begin
						j_q <= CW1'(i_q) + CW1'(2);
						for (int m = 0; m < CORNERS; m++)
							rot_q[m] <= rot_q[(m + 2) % CORNERS];
					end
				end else if (near_ex && near_ey) begin
					hit_q <= 1'b1;
				end else begin
					if (!i_last) begin
						i_q <= i_q + CW'(1);
						for (int m = 0; m < CORNERS; m++)
							rot_q[m] <= rot_q[(m + 1) % CORNERS];
					end
				end
			end
			ST_M2: c_q <= 51'(prod);
			ST_M3: c_q <= c_q - 51'(prod);
			ST_M5: acc_q <= ACC_W'(prod) << 26;
			ST_M6: begin
				if (cross_hit) begin
					hit_q <= 1'b1;
				end else begin
					if (cnt_cond)
						par_q <= !par_q;
					if (!i_last) begin
						i_q <= i_q + CW'(1);
						for (int m = 0; m < CORNERS; m++)
							rot_q[m] <= rot_q[(m + 1) % CORNERS];
					end
				end
			end
			ST_SCAN: begin
				if (scan_stop) begin
					if (scan_opp)
						par_q <= !par_q;
					i_q <= j_q[CW-1:0];
				end else begin
					j_q <= j_q + CW1'(1);
					for (int m = 0; m < CORNERS; m++)
						rot_q[m] <= rot_q[(m + 1) % CORNERS];
				end
			end
			ST_REG_END: begin
				if (hit_now) begin
					found_q <= 1'b1;
					idx_q   <= 4'(r_q);
				end else if (!r_last) begin
					r_q <= r_q + RW'(1);
				end
			end
			default: ;
		endcase
	end

	a_div_only_converting: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_CX_DIV || state_q == ST_CY_DIV))
		else $error("divider busy outside conversion");

	a_load_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> en_q[r_q])
		else $error("loading corners of a disabled region");

	a_hit_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REG_END && hit_now) |-> en_q[r_q])
		else $error("hit reported on a disabled region");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the done state");

endmodule
